// File: design/ptrs_pkg.sv
// Shared types and constants of the packet transfer retry sequencer.
`timescale 1ns / 1ps

package ptrs_pkg;

	// result action codes
	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_ISSUE = 2'd1,
		ACT_OK    = 2'd2,
		ACT_FAIL  = 2'd3
	} action_t;

	// configuration register indexes
	localparam logic [1:0] REG_IMAGE_SIZE    = 2'd0;
	localparam logic [1:0] REG_SIZE_CHECKSUM = 2'd1;
	localparam logic [1:0] REG_IMAGE_TAG     = 2'd2;
	localparam logic [1:0] REG_STORAGE_BASE  = 2'd3;

	localparam int unsigned SIZE_W  = 24;
	localparam int unsigned INDEX_W = 17;
	localparam int unsigned LEN_W   = 10;

	localparam logic [11:0]        TIMEOUT_TICKS = 12'd3000;
	localparam logic [5:0]         RESEND_TICKS  = 6'd34;
	localparam logic [1:0]         MAX_MISSED    = 2'd3;
	localparam logic [4:0]         MAX_REFUSED   = 5'd30;
	localparam logic [7:0]         TAG_HIGH      = 8'h45;	// 'E'
	localparam logic [7:0]         TAG_LOW       = 8'h49;	// 'I'
	localparam logic [LEN_W-1:0]   EXT_HEADER    = 10'd21;
	localparam logic [LEN_W-1:0]   SHORT_HEADER  = 10'd4;
	localparam logic [INDEX_W-1:0] TOTAL_MAX     = 17'h1FFFF;

endpackage

// File: design/packet_transfer_retry_sequencer_core.sv
// Stop-and-wait packet sender: header check, packet issue, acknowledge wait and retry.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------------
//  in      | to core   | in_valid/in_stall  | mode, send_accepted, response_status
//  out     | from core | out_valid/out_stall| action, packet_number, packet_count,
//          |           |                    | read_address, frame_length, first_frame, updating
//  cfg     | to core   | cfg_we             | cfg_index, cfg_data
//
// One request a cycle while in_stall is low: a tick yields its result in the output register
// in the cycle after it is taken; a response yields none. A new request is taken in the cycle
// the waiting result leaves. After reset and after each image_size write, in_stall holds while
// the packet count and last length are derived (reciprocal multiply, then remainder stage).
// in_stall also rises while a result sits in the output register under out_stall.
`timescale 1ns / 1ps

module packet_transfer_retry_sequencer_core #(
	parameter int unsigned PACKET_BYTES = 200
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic        send_accepted,
	input  logic [7:0]  response_status,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic [16:0] packet_number,
	output logic [16:0] packet_count,
	output logic [31:0] read_address,
	output logic [9:0]  frame_length,
	output logic        first_frame,
	output logic        updating,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned SW    = ptrs_pkg::SIZE_W;
	localparam int unsigned IW    = ptrs_pkg::INDEX_W;
	localparam int unsigned LW    = ptrs_pkg::LEN_W;
	localparam int unsigned LOG_D = $clog2(PACKET_BYTES);
	localparam int unsigned SHIFT = SW + LOG_D;
	// ceil(2^SHIFT / D): exact quotient for every 24-bit size
	localparam logic [SW:0] RECIP =
		(SW+1)'(((64'd1 << SHIFT) + 64'(PACKET_BYTES) - 64'd1) / 64'(PACKET_BYTES));
	localparam logic [LW-1:0] PB_LEN    = LW'(PACKET_BYTES);
	localparam logic [LW-1:0] FIRST_LEN = ptrs_pkg::EXT_HEADER + LW'(PACKET_BYTES);
	localparam logic [LW-1:0] MID_LEN   = ptrs_pkg::SHORT_HEADER + LW'(PACKET_BYTES);

	typedef enum logic [2:0] {
		PH_VALIDATE = 3'd0,
		PH_SEND     = 3'd1,
		PH_WAIT     = 3'd2,
		PH_REPORT   = 3'd3,
		PH_ABORT    = 3'd4
	} phase_t;

	// configuration
	logic [SW-1:0] image_size_q;
	logic [7:0]    size_checksum_q;
	logic [15:0]   image_tag_q;
	logic [31:0]   storage_base_q;
	logic [1:0]    settle_q;

	// derived size figures
	logic [2*SW:0] size_prod;
	logic [SW-1:0] quo_s1;
	logic [SW-1:0] rem_full;
	logic [SW:0]   total_full;
	logic [IW-1:0] total_s2;
	logic          oversize_s2;
	logic [LW-1:0] last_s2;

	// sequencer state
	phase_t        phase_q, phase_d;
	logic [11:0]   tick_q, tick_d;
	logic [5:0]    ack_wait_q, ack_wait_d;
	logic [1:0]    missed_q, missed_d;
	logic [4:0]    fails_q, fails_d;
	logic [IW-1:0] index_q, index_d;
	logic [IW-1:0] total_q, total_d;
	logic [LW-1:0] last_q, last_d;
	logic [31:0]   offset_q, offset_d;
	logic          success_q, success_d;
	logic          busy_q, busy_d;
	logic          ack_q, ack_d;

	// result being built
	ptrs_pkg::action_t res_action;
	logic [IW-1:0] res_number, res_count;
	logic [31:0]   res_address;
	logic [LW-1:0] res_length;
	logic          res_first;
	logic          res_updating;

	logic          out_valid_q;
	logic [1:0]    action_q;
	logic [IW-1:0] number_q, count_q;
	logic [31:0]   address_q;
	logic [LW-1:0] length_q;
	logic          first_q, updating_q;

	logic          can_load, take, tick;
	logic [7:0]    size_sum;
	logic [IW:0]   next_index;
	logic [5:0]    ack_wait_inc;
	logic [1:0]    missed_inc;
	logic [4:0]    fails_inc;

	assign can_load = !out_valid_q || !out_stall;
	assign in_stall = !can_load || (settle_q != 2'd0);
	assign take     = in_valid && !in_stall;
	assign tick     = take && !mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q    <= '0;
			size_checksum_q <= '0;
			image_tag_q     <= '0;
			storage_base_q  <= '0;
			settle_q        <= 2'd2;
		end else begin
			if (settle_q != 2'd0)
				settle_q <= settle_q - 2'd1;
			if (cfg_we) begin
				unique case (cfg_index)
					ptrs_pkg::REG_IMAGE_SIZE: begin
						image_size_q <= cfg_data[SW-1:0];
						settle_q     <= 2'd2;
					end
					ptrs_pkg::REG_SIZE_CHECKSUM: size_checksum_q <= cfg_data[7:0];
					ptrs_pkg::REG_IMAGE_TAG:     image_tag_q     <= cfg_data[15:0];
					ptrs_pkg::REG_STORAGE_BASE:  storage_base_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// size / PACKET_BYTES by reciprocal, then remainder and round-up
	assign size_prod  = (2*SW+1)'(image_size_q) * (2*SW+1)'(RECIP);
	assign rem_full   = image_size_q - SW'(quo_s1 * SW'(PACKET_BYTES));
	assign total_full = {1'b0, quo_s1} + (SW+1)'(rem_full != '0);

	always_ff @(posedge clk) begin
		quo_s1      <= SW'(size_prod >> SHIFT);
		total_s2    <= total_full[IW-1:0];
		oversize_s2 <= total_full > (SW+1)'(ptrs_pkg::TOTAL_MAX);
		last_s2     <= (rem_full != '0) ? rem_full[LW-1:0] : PB_LEN;
	end

	assign size_sum     = image_size_q[23:16] + image_size_q[15:8] + image_size_q[7:0];
	assign next_index   = {1'b0, index_q} + (IW+1)'(1);
	assign ack_wait_inc = ack_wait_q + 6'd1;
	assign missed_inc   = missed_q + 2'd1;
	assign fails_inc    = fails_q + 5'd1;

	always_comb begin
		phase_t ph;

		phase_d    = phase_q;
		tick_d     = tick_q;
		ack_wait_d = ack_wait_q;
		missed_d   = missed_q;
		fails_d    = fails_q;
		index_d    = index_q;
		total_d    = total_q;
		last_d     = last_q;
		offset_d   = offset_q;
		success_d  = success_q;
		busy_d     = busy_q;
		ack_d      = ack_q;

		res_action  = ptrs_pkg::ACT_NONE;
		res_number  = '0;
		res_count   = '0;
		res_address = '0;
		res_length  = '0;
		res_first   = 1'b0;
		ph          = phase_q;

		if (take && mode) begin
			if (response_status == 8'd0)
				ack_d = 1'b1;
		end else if (tick) begin
			tick_d = tick_q + 12'd1;
			if (tick_d >= ptrs_pkg::TIMEOUT_TICKS) begin
				tick_d = '0;
				ph     = PH_ABORT;
			end
			unique case (ph)
				PH_VALIDATE: begin
					if (size_sum != size_checksum_q) begin
						phase_d = PH_ABORT;
					end else begin
						last_d = last_s2;
						if (oversize_s2 || image_tag_q != {ptrs_pkg::TAG_HIGH, ptrs_pkg::TAG_LOW}) begin
							phase_d = PH_ABORT;
						end else begin
							index_d  = IW'(1);
							total_d  = total_s2;
							offset_d = '0;
							phase_d  = PH_SEND;
							busy_d   = 1'b1;
						end
					end
				end
				PH_SEND: begin
					if (index_q == '0 || index_q > total_q) begin
						success_d = 1'b0;
						phase_d   = PH_REPORT;
					end else begin
						res_action  = ptrs_pkg::ACT_ISSUE;
						res_number  = index_q;
						res_count   = total_q;
						res_address = storage_base_q + offset_q;
						res_first   = (index_q == IW'(1));
						if (res_first)
							res_length = FIRST_LEN;
						else if (index_q == total_q)
							res_length = ptrs_pkg::SHORT_HEADER + last_q;
						else
							res_length = MID_LEN;
						if (send_accepted) begin
							phase_d    = PH_WAIT;
							ack_wait_d = '0;
							fails_d    = '0;
						end else begin
							fails_d = fails_inc;
							if (fails_inc >= ptrs_pkg::MAX_REFUSED) begin
								success_d = 1'b0;
								phase_d   = PH_REPORT;
							end
						end
					end
				end
				PH_WAIT: begin
					if (ack_q) begin
						ack_d    = 1'b0;
						missed_d = '0;
						phase_d  = PH_SEND;
						index_d  = next_index[IW-1:0];
						offset_d = offset_q + 32'(PACKET_BYTES);
						if (next_index > {1'b0, total_q}) begin
							total_d   = '0;
							success_d = 1'b1;
							phase_d   = PH_REPORT;
						end
					end else begin
						ack_wait_d = ack_wait_inc;
						if (ack_wait_inc >= ptrs_pkg::RESEND_TICKS) begin
							phase_d    = PH_SEND;
							ack_wait_d = '0;
							missed_d   = missed_inc;
							if (missed_inc >= ptrs_pkg::MAX_MISSED) begin
								missed_d  = '0;
								success_d = 1'b0;
								phase_d   = PH_REPORT;
							end
						end
					end
				end
				default: begin
					// report, abort: give the verdict and start over
					if (ph == PH_REPORT && success_q)
						res_action = ptrs_pkg::ACT_OK;
					else
						res_action = ptrs_pkg::ACT_FAIL;
					phase_d    = PH_VALIDATE;
					tick_d     = '0;
					ack_wait_d = '0;
					missed_d   = '0;
					fails_d    = '0;
					index_d    = '0;
					total_d    = '0;
					last_d     = '0;
					offset_d   = '0;
					success_d  = 1'b0;
					busy_d     = 1'b0;
					ack_d      = 1'b0;
				end
			endcase
		end

		res_updating = (res_action == ptrs_pkg::ACT_NONE || res_action == ptrs_pkg::ACT_ISSUE)
			? busy_d : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_VALIDATE;
			tick_q      <= '0;
			ack_wait_q  <= '0;
			missed_q    <= '0;
			fails_q     <= '0;
			index_q     <= '0;
			total_q     <= '0;
			last_q      <= '0;
			offset_q    <= '0;
			success_q   <= 1'b0;
			busy_q      <= 1'b0;
			ack_q       <= 1'b0;
			out_valid_q <= 1'b0;
			action_q    <= '0;
			number_q    <= '0;
			count_q     <= '0;
			address_q   <= '0;
			length_q    <= '0;
			first_q     <= 1'b0;
			updating_q  <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			tick_q     <= tick_d;
			ack_wait_q <= ack_wait_d;
			missed_q   <= missed_d;
			fails_q    <= fails_d;
			index_q    <= index_d;
			total_q    <= total_d;
			last_q     <= last_d;
			offset_q   <= offset_d;
			success_q  <= success_d;
			busy_q     <= busy_d;
			ack_q      <= ack_d;
			if (can_load) begin
				out_valid_q <= tick;
				action_q    <= res_action;
				number_q    <= res_number;
				count_q     <= res_count;
				address_q   <= res_address;
				length_q    <= res_length;
				first_q     <= res_first;
				updating_q  <= res_updating;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = action_q;
	assign packet_number = number_q;
	assign packet_count  = count_q;
	assign read_address  = address_q;
	assign frame_length  = length_q;
	assign first_frame   = first_q;
	assign updating      = updating_q;

endmodule

// File: dv/packet_transfer_retry_sequencer_core_tb.sv
// Testbench for the packet transfer retry sequencer core: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module packet_transfer_retry_sequencer_core_tb;

	localparam int unsigned PKT_BYTES     = 200;
	localparam int unsigned EXT_HDR       = 21;
	localparam int unsigned SHORT_HDR     = 4;
	localparam int unsigned TICK_LIMIT    = 3000;
	localparam int unsigned RESEND_WAIT   = 34;
	localparam int unsigned MISS_LIMIT    = 3;
	localparam int unsigned REFUSAL_LIMIT = 30;
	localparam int unsigned MAX_PACKETS   = 131071;
	localparam logic [15:0] IMAGE_TAG     = 16'h4549;

	localparam logic       MODE_TICK  = 1'b0;
	localparam logic       MODE_RESP  = 1'b1;
	localparam logic [7:0] STATUS_ACK = 8'h00;

	localparam int unsigned IDLE_PCT      = 23;
	localparam int unsigned RANDOM_TICKS  = 730;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned DRAIN_CYCLES  = 20000;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned REPORT_CAP    = 40;

	typedef enum logic [2:0] {
		PH_CHECK  = 3'd0,
		PH_SEND   = 3'd1,
		PH_WAIT   = 3'd2,
		PH_REPORT = 3'd3,
		PH_ABORT  = 3'd4
	} seq_phase_t;

	typedef struct packed {
		ptrs_pkg::action_t act;
		logic [16:0] number;
		logic [16:0] count;
		logic [31:0] address;
		logic [9:0]  length;
		logic        first;
		logic        busy;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = 1'b0;
	logic        send_accepted = 1'b0;
	logic [7:0]  response_status = 8'h00;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  action;
	logic [16:0] packet_number;
	logic [16:0] packet_count;
	logic [31:0] read_address;
	logic [9:0]  frame_length;
	logic        first_frame;
	logic        updating;

	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [31:0] cfg_data = 32'd0;

	packet_transfer_retry_sequencer_core #(
		.PACKET_BYTES(PKT_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.send_accepted(send_accepted),
		.response_status(response_status),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.packet_number(packet_number),
		.packet_count(packet_count),
		.read_address(read_address),
		.frame_length(frame_length),
		.first_frame(first_frame),
		.updating(updating),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// register copies
	logic [23:0] img_size = '0;
	logic [7:0]  img_sum  = '0;
	logic [15:0] img_tag  = '0;
	logic [31:0] img_base = '0;

	// sequencer state as predicted
	seq_phase_t  seq_phase;
	logic [11:0] tick_no;
	logic [5:0]  wait_ticks;
	logic [1:0]  misses;
	logic [4:0]  refusals;
	logic [16:0] pkt_idx;
	logic [16:0] pkt_total;
	logic [9:0]  tail_len;
	logic        ok_flag;
	logic        busy;
	logic        ack_seen;

	frame_result_t awaited_outcomes[$];

	int unsigned mismatches = 0;
	int unsigned requests_sent = 0;
	int unsigned ticks_sent = 0;
	int unsigned outcomes_checked = 0;
	int unsigned header_loads = 0;
	int unsigned updates_ok = 0;
	int unsigned updates_failed = 0;
	int unsigned timeouts = 0;
	int unsigned cycle_count = 0;
	logic        steady_flow = 1'b0;

	function automatic logic [7:0] byte_sum(input logic [23:0] size);
		return size[23:16] + size[15:8] + size[7:0];
	endfunction

	function automatic void clear_progress();
		seq_phase  = PH_CHECK;
		tick_no    = '0;
		wait_ticks = '0;
		misses     = '0;
		refusals   = '0;
		pkt_idx    = '0;
		pkt_total  = '0;
		tail_len   = '0;
		ok_flag    = 1'b0;
		busy       = 1'b0;
		ack_seen   = 1'b0;
	endfunction

	// Outcome of one tick; advances the predicted state.
	function automatic void tick_outcome(input logic accepted, output frame_result_t r);
		int unsigned total;
		int unsigned rest;
		int unsigned next_idx;
		r = '0;
		tick_no = tick_no + 12'd1;
		if (tick_no >= 12'(TICK_LIMIT)) begin
			tick_no = '0;
			seq_phase = PH_ABORT;
			timeouts++;
		end
		case (seq_phase)
			PH_CHECK: begin
				if (byte_sum(img_size) != img_sum) begin
					seq_phase = PH_ABORT;
				end else begin
					total = 32'(img_size) / PKT_BYTES;
					rest = 32'(img_size) % PKT_BYTES;
					if (rest != 0) begin
						total++;
						tail_len = 10'(rest);
					end else begin
						tail_len = 10'(PKT_BYTES);
					end
					if (total > MAX_PACKETS || img_tag != IMAGE_TAG) begin
						seq_phase = PH_ABORT;
					end else begin
						pkt_idx = 17'd1;
						pkt_total = 17'(total);
						seq_phase = PH_SEND;
						busy = 1'b1;
					end
				end
			end
			PH_SEND: begin
				if (pkt_idx == 17'd0 || pkt_idx > pkt_total) begin
					// nothing left to send: empty image lands here
					ok_flag = 1'b0;
					seq_phase = PH_REPORT;
				end else begin
					r.act = ptrs_pkg::ACT_ISSUE;
					r.number = pkt_idx;
					r.count = pkt_total;
					r.address = img_base + (32'(pkt_idx) - 32'd1) * PKT_BYTES;
					r.first = (pkt_idx == 17'd1);
					if (pkt_idx == 17'd1) r.length = 10'(EXT_HDR + PKT_BYTES);
					else if (pkt_idx == pkt_total) r.length = 10'(SHORT_HDR) + tail_len;
					else r.length = 10'(SHORT_HDR + PKT_BYTES);
					if (accepted) begin
						seq_phase = PH_WAIT;
						wait_ticks = '0;
						refusals = '0;
					end else begin
						refusals = refusals + 5'd1;
						if (refusals >= 5'(REFUSAL_LIMIT)) begin
							ok_flag = 1'b0;
							seq_phase = PH_REPORT;
						end
					end
				end
			end
			PH_WAIT: begin
				if (ack_seen) begin
					next_idx = 32'(pkt_idx) + 32'd1;
					ack_seen = 1'b0;
					misses = '0;
					seq_phase = PH_SEND;
					if (next_idx > 32'(pkt_total)) begin
						pkt_total = '0;
						ok_flag = 1'b1;
						seq_phase = PH_REPORT;
					end
					pkt_idx = 17'(next_idx);
				end else begin
					wait_ticks = wait_ticks + 6'd1;
					if (wait_ticks >= 6'(RESEND_WAIT)) begin
						seq_phase = PH_SEND;
						wait_ticks = '0;
						misses = misses + 2'd1;
						if (misses >= 2'(MISS_LIMIT)) begin
							misses = '0;
							ok_flag = 1'b0;
							seq_phase = PH_REPORT;
						end
					end
				end
			end
			default: begin
				// report phase, abort phase and the unused codes
				r.act = (seq_phase == PH_REPORT && ok_flag) ? ptrs_pkg::ACT_OK
					: ptrs_pkg::ACT_FAIL;
				if (r.act == ptrs_pkg::ACT_OK) updates_ok++;
				else updates_failed++;
				clear_progress();
			end
		endcase
		r.busy = busy;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= REPORT_CAP)
			$display("MISMATCH %s: got 0x%0h, expected 0x%0h (t=%0t)", what, got, want, $time);
	endtask

	task automatic check_outcome();
		frame_result_t want;
		if (awaited_outcomes.size() == 0) begin
			report_mismatch("result with none pending, action", 64'(action), 64'd0);
		end else begin
			want = awaited_outcomes.pop_front();
			outcomes_checked++;
			if (action !== want.act) report_mismatch("action", 64'(action), 64'(want.act));
			if (packet_number !== want.number)
				report_mismatch("packet_number", 64'(packet_number), 64'(want.number));
			if (packet_count !== want.count)
				report_mismatch("packet_count", 64'(packet_count), 64'(want.count));
			if (read_address !== want.address)
				report_mismatch("read_address", 64'(read_address), 64'(want.address));
			if (frame_length !== want.length)
				report_mismatch("frame_length", 64'(frame_length), 64'(want.length));
			if (first_frame !== want.first)
				report_mismatch("first_frame", 64'(first_frame), 64'(want.first));
			if (updating !== want.busy)
				report_mismatch("updating", 64'(updating), 64'(want.busy));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) check_outcome();
		out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) cycle_count++;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles with %0d results pending", cycle_count,
			awaited_outcomes.size());
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_request(input logic m, input logic acc, input logic [7:0] status);
		frame_result_t r;
		if (!steady_flow) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		mode <= m;
		send_accepted <= acc;
		response_status <= status;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
		if (m == MODE_TICK) begin
			tick_outcome(acc, r);
			awaited_outcomes.push_back(r);
			ticks_sent++;
		end else if (status == STATUS_ACK) begin
			ack_seen = 1'b1;
		end
	endtask

	// responses leave no result behind, so allow the pipeline to settle too
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (awaited_outcomes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ptrs_pkg::REG_IMAGE_SIZE:    img_size = value[23:0];
			ptrs_pkg::REG_SIZE_CHECKSUM: img_sum = value[7:0];
			ptrs_pkg::REG_IMAGE_TAG:     img_tag = value[15:0];
			ptrs_pkg::REG_STORAGE_BASE:  img_base = value;
			default: ;
		endcase
	endtask

	// unused upper data bits carry noise to check they are dropped
	task automatic load_image(input logic [23:0] size, input logic [7:0] sum,
			input logic [15:0] tag, input logic [31:0] base);
		wait_idle();
		write_register(ptrs_pkg::REG_IMAGE_SIZE, {8'($urandom), size});
		write_register(ptrs_pkg::REG_SIZE_CHECKSUM, {24'($urandom), sum});
		write_register(ptrs_pkg::REG_IMAGE_TAG, {16'($urandom), tag});
		write_register(ptrs_pkg::REG_STORAGE_BASE, base);
		header_loads++;
	endtask

	// Drive requests until the current transfer reports its result.
	task automatic run_update(input int unsigned ack_pct, input int unsigned accept_pct,
			input int unsigned noise_pct);
		int unsigned closed_at;
		closed_at = updates_ok + updates_failed;
		while (updates_ok + updates_failed == closed_at) begin
			if ($urandom_range(99) < noise_pct)
				send_request(MODE_RESP, 1'($urandom_range(1)), 8'($urandom_range(255)));
			else if (seq_phase == PH_WAIT && !ack_seen && $urandom_range(99) < ack_pct)
				send_request(MODE_RESP, 1'($urandom_range(1)), STATUS_ACK);
			else
				send_request(MODE_TICK, $urandom_range(99) < accept_pct,
					8'($urandom_range(255)));
		end
	endtask

	task automatic test_reset_defaults();
		// registers at reset: size and sum agree, tag does not
		send_request(MODE_RESP, 1'b1, STATUS_ACK);
		send_request(MODE_TICK, 1'b1, 8'hFF);
		send_request(MODE_TICK, 1'b0, 8'h00);
	endtask

	task automatic test_header_checks();
		load_image(24'hFFFFFF, 8'h00, IMAGE_TAG, 32'h0000_0000);
		run_update(100, 100, 0);
		load_image(24'hFFFFFF, byte_sum(24'hFFFFFF), 16'h4945, 32'hFFFF_FFFF);
		run_update(100, 100, 0);
		load_image(24'hFFFFFF, byte_sum(24'hFFFFFF), 16'hFFFF, 32'h0000_0000);
		run_update(100, 100, 0);
		// empty image passes the header but fails on the first send
		load_image(24'h000000, 8'h00, IMAGE_TAG, 32'hFFFF_FFFF);
		run_update(100, 100, 0);
	endtask

	task automatic test_transfers();
		load_image(24'd1, byte_sum(24'd1), IMAGE_TAG, 32'h0000_0000);
		run_update(100, 100, 0);
		// base just below the wrap point
		load_image(24'd401, byte_sum(24'd401), IMAGE_TAG, 32'hFFFF_FF38);
		run_update(100, 100, 0);
		load_image(24'h0000FF, 8'hFF, IMAGE_TAG, 32'hFFFF_FFFF);
		run_update(100, 100, 0);
		load_image(24'd600, byte_sum(24'd600), IMAGE_TAG, 32'h8000_0000);
		run_update(100, 100, 0);
	endtask

	task automatic test_refused_sends();
		load_image(24'd200, byte_sum(24'd200), IMAGE_TAG, 32'h0000_1000);
		send_request(MODE_TICK, 1'b1, 8'h00);
		repeat (REFUSAL_LIMIT - 1) send_request(MODE_TICK, 1'b0, 8'h00);
		send_request(MODE_TICK, 1'b1, 8'h00);
		run_update(100, 100, 0);
		load_image(24'd200, byte_sum(24'd200), IMAGE_TAG, 32'h0000_1000);
		run_update(100, 0, 0);
	endtask

	task automatic test_stale_ack();
		load_image(24'd600, byte_sum(24'd600), IMAGE_TAG, 32'h1000_0000);
		// acknowledge latched before the header check completes the first wait at once
		send_request(MODE_RESP, 1'b1, STATUS_ACK);
		send_request(MODE_TICK, 1'b0, 8'hFF);
		send_request(MODE_TICK, 1'b1, 8'hFF);
		send_request(MODE_TICK, 1'b1, 8'h00);
		send_request(MODE_RESP, 1'b0, 8'h01);
		send_request(MODE_RESP, 1'b1, 8'hFF);
		run_update(100, 100, 0);
	endtask

	task automatic test_missed_acks();
		load_image(24'hFFFFFF, byte_sum(24'hFFFFFF), IMAGE_TAG, 32'hFFFF_FFFF);
		// long run with no idling on either side
		steady_flow = 1'b1;
		run_update(0, 100, 0);
		steady_flow = 1'b0;
	endtask

	task automatic test_random_sessions();
		int unsigned start;
		int unsigned pick;
		logic [23:0] size;
		logic [7:0]  sum;
		logic [15:0] tag;
		logic [31:0] base;
		int unsigned ack_pct;
		int unsigned accept_pct;
		start = ticks_sent;
		while (ticks_sent - start < RANDOM_TICKS) begin
			pick = $urandom_range(99);
			if (pick < 60) size = 24'($urandom_range(1, 2200));
			else if (pick < 75) size = 24'(PKT_BYTES * $urandom_range(1, 11));
			else if (pick < 85) size = 24'($urandom_range(0, 3));
			else size = 24'($urandom);
			sum = ($urandom_range(99) < 85) ? byte_sum(size) : 8'($urandom);
			tag = ($urandom_range(99) < 85) ? IMAGE_TAG : 16'($urandom);
			pick = $urandom_range(99);
			if (pick < 10) base = 32'h0000_0000;
			else if (pick < 20) base = 32'hFFFF_FFFF - 32'($urandom_range(0, 1000));
			else base = $urandom;
			pick = $urandom_range(99);
			if (size > 24'd4000) ack_pct = 0;
			else if (pick < 75) ack_pct = $urandom_range(60, 100);
			else ack_pct = $urandom_range(0, 40);
			pick = $urandom_range(99);
			if (pick < 65) accept_pct = $urandom_range(75, 100);
			else if (pick < 85) accept_pct = $urandom_range(20, 60);
			else accept_pct = $urandom_range(0, 5);
			load_image(size, sum, tag, base);
			run_update(ack_pct, accept_pct, $urandom_range(0, 12));
		end
	endtask

	initial begin
		int unsigned drain;
		clear_progress();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_header_checks();
		test_transfers();
		test_refused_sends();
		test_stale_ack();
		test_missed_acks();
		test_random_sessions();
		in_valid <= 1'b0;
		drain = 0;
		while (awaited_outcomes.size() != 0 && drain < DRAIN_CYCLES) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_outcomes.size() != 0)
			report_mismatch("results never delivered", 64'(awaited_outcomes.size()), 64'd0);
		$display("Sent %0d requests (%0d ticks), checked %0d results over %0d header loads.",
			requests_sent, ticks_sent, outcomes_checked, header_loads);
		$display("%0d transfers succeeded, %0d failed or aborted (%0d on the overall timeout).",
			updates_ok, updates_failed, timeouts);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
